// ===== hw/rtl/sol2_pkg.sv =====
// Shared types for the 2x2 solve / inverse pipeline.
package sol2_pkg;

    localparam int Lanes    = 4;
    localparam int QuoBits  = 33;
    localparam int DivSteps = 33;

    localparam logic ModeSolve   = 1'b0;
    localparam logic ModeInverse = 1'b1;

    typedef struct packed {
        logic               mode;
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
        logic signed [31:0] rhs0;
        logic signed [31:0] rhs1;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] res0;
        logic signed [31:0] res1;
        logic signed [31:0] res2;
        logic signed [31:0] res3;
        logic signed [63:0] det_value;
        logic               singular;
        logic               saturated;
    } t_out_word;

    // determinant and numerators after the product stage
    typedef struct packed {
        logic               mode;
        logic signed [63:0] det;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic signed [31:0] a00;
        logic signed [31:0] a01;
        logic signed [31:0] a10;
        logic signed [31:0] a11;
    } t_front;

    // per-lane signed magnitudes
    typedef struct packed {
        logic                    mode;
        logic signed [63:0]      det;
        logic                    dneg;
        logic [63:0]             dmag;
        logic [Lanes-1:0]        nneg;
        logic [Lanes-1:0][63:0]  nmag;
    } t_lane_word;

    // state carried through the divider steps
    typedef struct packed {
        logic signed [63:0]             det;
        logic                           singular;
        logic [63:0]                    dmag;
        logic [Lanes-1:0]               big;
        logic [Lanes-1:0]               neg;
        logic [Lanes-1:0][63:0]         rem;
        logic [Lanes-1:0][QuoBits-1:0]  lowb;
        logic [Lanes-1:0][QuoBits-1:0]  quo;
    } t_div_word;

endpackage

// ===== hw/rtl/solve_or_invert_2x2_top.sv =====
// Top level of the 2x2 Cramer solve / inverse pipeline.
// Takes one word per cycle while not stalled and returns one result word per input word,
// in order, after 32x32 products and differences, sign split and divider setup,
// 33 restoring-division steps (one quotient bit per stage, four lanes in parallel),
// and one saturation/output stage. The whole pipeline holds when the output word
// is stalled; o_stall is high only then.
module solve_or_invert_2x2_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  sol2_pkg::t_in_word  i_data,
    output logic                o_valid,
    input  logic                i_stall,
    output sol2_pkg::t_out_word o_data
);
    logic                en;
    logic                front_valid;
    sol2_pkg::t_front    front_data;
    logic                div_valid [sol2_pkg::DivSteps+1];
    sol2_pkg::t_div_word div_data  [sol2_pkg::DivSteps+1];
    sol2_pkg::t_out_word r_out, n_out;
    logic                r_out_valid;

    assign en      = !(r_out_valid && i_stall);
    assign o_stall = !en;

    sol2_front u_front (
        .i_clk, .i_rst_n, .i_en(en), .i_valid, .i_data,
        .o_valid(front_valid), .o_data(front_data)
    );

    sol2_prep u_prep (
        .i_clk, .i_rst_n, .i_en(en), .i_valid(front_valid), .i_data(front_data),
        .o_valid(div_valid[0]), .o_data(div_data[0])
    );

    for (genvar g = 0; g < sol2_pkg::DivSteps; g++) begin : g_step
        sol2_div_step u_step (
            .i_clk, .i_rst_n, .i_en(en),
            .i_valid(div_valid[g]), .i_data(div_data[g]),
            .o_valid(div_valid[g+1]), .o_data(div_data[g+1])
        );
    end

    logic [31:0] lane_res [sol2_pkg::Lanes];
    logic [sol2_pkg::Lanes-1:0] lane_sat;

    always_comb begin
        sol2_pkg::t_div_word d;
        d = div_data[sol2_pkg::DivSteps];
        for (int k = 0; k < sol2_pkg::Lanes; k++) begin
            if (d.neg[k]) begin
                lane_sat[k] = d.big[k] || (d.quo[k] > 33'h0_8000_0000);
                lane_res[k] = lane_sat[k] ? 32'h8000_0000 : 32'(-d.quo[k]);
            end else begin
                lane_sat[k] = d.big[k] || (d.quo[k] > 33'h0_7FFF_FFFF);
                lane_res[k] = lane_sat[k] ? 32'h7FFF_FFFF : d.quo[k][31:0];
            end
        end
        n_out.singular = d.singular;
        n_out.det_value = d.singular ? '0 : d.det;
        n_out.saturated = !d.singular && (lane_sat != '0);
        n_out.res0 = d.singular ? '0 : lane_res[0];
        n_out.res1 = d.singular ? '0 : lane_res[1];
        n_out.res2 = d.singular ? '0 : lane_res[2];
        n_out.res3 = d.singular ? '0 : lane_res[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= div_valid[sol2_pkg::DivSteps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

    a_sing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |-> o_data.res0 == '0 && o_data.res1 == '0 &&
            o_data.res2 == '0 && o_data.res3 == '0 && !o_data.saturated)
        else $error("singular word with nonzero results");

    a_det_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_data.singular == (o_data.det_value == '0)))
        else $error("singular flag disagrees with determinant");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(div_valid[sol2_pkg::DivSteps]))
        else $error("pipeline moved while stalled");
endmodule

// ===== hw/rtl/sol2_front.sv =====
// Products and differences: determinant and Cramer numerators.
module sol2_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  sol2_pkg::t_in_word i_data,
    output logic              o_valid,
    output sol2_pkg::t_front  o_data
);
    logic signed [63:0] r_p_a0011, r_p_a0110, r_p_a11r0, r_p_a01r1, r_p_a00r1, r_p_a10r0;
    logic               r_v1, r_v2;
    logic               r_mode1;
    logic signed [31:0] r_a00, r_a01, r_a10, r_a11;
    sol2_pkg::t_front   r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_a0011 <= i_data.a00 * i_data.a11;
            r_p_a0110 <= i_data.a01 * i_data.a10;
            r_p_a11r0 <= i_data.a11 * i_data.rhs0;
            r_p_a01r1 <= i_data.a01 * i_data.rhs1;
            r_p_a00r1 <= i_data.a00 * i_data.rhs1;
            r_p_a10r0 <= i_data.a10 * i_data.rhs0;
            r_mode1   <= i_data.mode;
            r_a00     <= i_data.a00;
            r_a01     <= i_data.a01;
            r_a10     <= i_data.a10;
            r_a11     <= i_data.a11;

            r_out.mode <= r_mode1;
            r_out.det  <= r_p_a0011 - r_p_a0110;
            r_out.nx   <= r_p_a11r0 - r_p_a01r1;
            r_out.ny   <= r_p_a00r1 - r_p_a10r0;
            r_out.a00  <= r_a00;
            r_out.a01  <= r_a01;
            r_out.a10  <= r_a10;
            r_out.a11  <= r_a11;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_out;
endmodule

// ===== hw/rtl/sol2_prep.sv =====
// Sign/magnitude split and divider setup for the four lanes.
module sol2_prep (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sol2_pkg::t_front     i_data,
    output logic                 o_valid,
    output sol2_pkg::t_div_word  o_data
);
    sol2_pkg::t_lane_word r_lane, n_lane;
    sol2_pkg::t_div_word  r_div, n_div;
    logic                 r_v1, r_v2;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        mag64 = v[63] ? 64'(-v) : 64'(v);
    endfunction

    always_comb begin
        n_lane.mode = i_data.mode;
        n_lane.det  = i_data.det;
        n_lane.dneg = i_data.det[63];
        n_lane.dmag = mag64(i_data.det);
        if (i_data.mode == sol2_pkg::ModeSolve) begin
            n_lane.nneg = {2'b00, i_data.ny[63], i_data.nx[63]};
            n_lane.nmag[0] = mag64(i_data.nx);
            n_lane.nmag[1] = mag64(i_data.ny);
            n_lane.nmag[2] = '0;
            n_lane.nmag[3] = '0;
        end else begin
            // adjugate [a11, -a01; -a10, a00]
            n_lane.nneg[0] = i_data.a11[31];
            n_lane.nneg[1] = !i_data.a01[31] && (i_data.a01 != '0);
            n_lane.nneg[2] = !i_data.a10[31] && (i_data.a10 != '0);
            n_lane.nneg[3] = i_data.a00[31];
            n_lane.nmag[0] = mag64(64'(i_data.a11));
            n_lane.nmag[1] = mag64(64'(i_data.a01));
            n_lane.nmag[2] = mag64(64'(i_data.a10));
            n_lane.nmag[3] = mag64(64'(i_data.a00));
        end
    end

    always_comb begin
        n_div.det      = r_lane.det;
        n_div.singular = (r_lane.dmag == '0);
        n_div.dmag     = r_lane.dmag;
        n_div.quo      = '0;
        for (int k = 0; k < sol2_pkg::Lanes; k++) begin
            // numerator is nmag << 16 (solve) or << 32 (inverse)
            if (r_lane.mode == sol2_pkg::ModeInverse) begin
                n_div.rem[k]  = {1'b0, r_lane.nmag[k][63:1]};
                n_div.lowb[k] = {r_lane.nmag[k][0], 32'b0};
            end else begin
                n_div.rem[k]  = {17'b0, r_lane.nmag[k][63:17]};
                n_div.lowb[k] = {r_lane.nmag[k][16:0], 16'b0};
            end
            n_div.big[k] = (n_div.rem[k] >= r_lane.dmag);
            n_div.neg[k] = r_lane.nneg[k] ^ r_lane.dneg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
            r_div  <= n_div;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_div;
endmodule

// ===== hw/rtl/sol2_div_step.sv =====
// One restoring-division step across all lanes.
module sol2_div_step (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  sol2_pkg::t_div_word  i_data,
    output logic                 o_valid,
    output sol2_pkg::t_div_word  o_data
);
    sol2_pkg::t_div_word r_data, n_data;
    logic                r_valid;
    logic [64:0]         trial [sol2_pkg::Lanes];

    always_comb begin
        n_data = i_data;
        for (int k = 0; k < sol2_pkg::Lanes; k++) begin
            trial[k] = {i_data.rem[k], i_data.lowb[k][sol2_pkg::QuoBits-1]};
            n_data.lowb[k] = {i_data.lowb[k][sol2_pkg::QuoBits-2:0], 1'b0};
            if (trial[k] >= {1'b0, i_data.dmag}) begin
                n_data.rem[k] = 64'(trial[k] - {1'b0, i_data.dmag});
                n_data.quo[k] = {i_data.quo[k][sol2_pkg::QuoBits-2:0], 1'b1};
            end else begin
                n_data.rem[k] = trial[k][63:0];
                n_data.quo[k] = {i_data.quo[k][sol2_pkg::QuoBits-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule

// ===== tb/sv/tb_solve_or_invert_2x2_top.sv =====
// Testbench for the 2x2 Cramer solve / inverse pipeline: random and directed words.
`timescale 1ns / 100ps

module tb_solve_or_invert_2x2_top;

    localparam int   PipeDepth   = 38;
    localparam int   IdleLimit   = 4000;
    localparam int   NumRandom   = 1450;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    sol2_pkg::t_in_word  i_data;
    logic                o_valid;
    logic                i_stall;
    sol2_pkg::t_out_word o_data;

    solve_or_invert_2x2_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    sol2_pkg::t_in_word  pending_words[$];
    sol2_pkg::t_out_word expected_results[$];
    int        n_errors = 0;
    int        n_checked = 0;
    int        n_inv = 0;
    int        n_singular = 0;
    int        n_clipped = 0;
    int        idle_cycles = 0;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    bit        stim_done;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // truncating signed divide of (nmag << sh) by dmag, clipped to 32 bits
    function automatic logic [31:0] clip_quotient(input bit nneg, input logic [63:0] nmag,
                                                  input int sh, input bit dneg,
                                                  input logic [63:0] dmag,
                                                  inout bit clipped);
        logic [127:0] num;
        logic [127:0] quo;
        num = {64'd0, nmag} << sh;
        quo = num / {64'd0, dmag};
        if (nneg != dneg) begin
            if (quo > 128'h8000_0000) begin
                clipped = 1'b1;
                return 32'h8000_0000;
            end
            return 32'(-quo);
        end
        if (quo > 128'h7FFF_FFFF) begin
            clipped = 1'b1;
            return 32'h7FFF_FFFF;
        end
        return quo[31:0];
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : v;
    endfunction

    function automatic sol2_pkg::t_out_word solve_2x2(input sol2_pkg::t_in_word w);
        sol2_pkg::t_out_word r;
        logic signed [63:0] det;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic [63:0]        dmag;
        bit                 clipped;
        bit                 dneg;
        r = '0;
        clipped = 1'b0;
        det = 64'(w.a00) * 64'(w.a11) - 64'(w.a01) * 64'(w.a10);
        if (det == 0) begin
            r.singular = 1'b1;
            return r;
        end
        r.det_value = det;
        dneg = det[63];
        dmag = magnitude(det);
        if (w.mode == sol2_pkg::ModeSolve) begin
            nx = 64'(w.a11) * 64'(w.rhs0) - 64'(w.a01) * 64'(w.rhs1);
            ny = 64'(w.a00) * 64'(w.rhs1) - 64'(w.a10) * 64'(w.rhs0);
            r.res0 = clip_quotient(nx[63], magnitude(nx), 16, dneg, dmag, clipped);
            r.res1 = clip_quotient(ny[63], magnitude(ny), 16, dneg, dmag, clipped);
        end else begin
            r.res0 = clip_quotient(w.a11 < 0, magnitude(64'(w.a11)), 32, dneg, dmag, clipped);
            r.res1 = clip_quotient(w.a01 > 0, magnitude(64'(w.a01)), 32, dneg, dmag, clipped);
            r.res2 = clip_quotient(w.a10 > 0, magnitude(64'(w.a10)), 32, dneg, dmag, clipped);
            r.res3 = clip_quotient(w.a00 < 0, magnitude(64'(w.a00)), 32, dneg, dmag, clipped);
        end
        r.saturated = clipped;
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at word %0d: %s got %h want %h", n_checked, field, got, want);
        n_errors++;
    endtask

    function automatic logic [31:0] rand_entry();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'(int'($urandom_range(0, 8)) - 4) << 16;
            3: return 32'(int'($urandom_range(0, 1024)) - 512);
            4: return 32'(int'($urandom_range(0, 65535)) - 32768) << $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_word(input logic mode, input logic [31:0] a00, input logic [31:0] a01,
                            input logic [31:0] a10, input logic [31:0] a11,
                            input logic [31:0] r0, input logic [31:0] r1);
        sol2_pkg::t_in_word w;
        w.mode = mode;
        w.a00 = a00;
        w.a01 = a01;
        w.a10 = a10;
        w.a11 = a11;
        w.rhs0 = r0;
        w.rhs1 = r1;
        pending_words.push_back(w);
    endtask

    initial begin
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
        int          k;
        stim_done = 1'b0;
        // identity, both modes
        add_word(sol2_pkg::ModeSolve, 32'h1_0000, 0, 0, 32'h1_0000, 32'h3_0000, 32'hFFFE_0000);
        add_word(sol2_pkg::ModeInverse, 32'h1_0000, 0, 0, 32'h1_0000, 32'h1234, 32'h5678);
        // singular matrices
        add_word(sol2_pkg::ModeSolve, 32'h2_0000, 32'h4_0000, 32'h1_0000, 32'h2_0000,
                 32'h1_0000, 1);
        add_word(sol2_pkg::ModeInverse, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'h8000_0000);
        add_word(sol2_pkg::ModeInverse, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h8000_0000, 0, 0);
        // extreme entries
        add_word(sol2_pkg::ModeSolve, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_word(sol2_pkg::ModeInverse, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_word(sol2_pkg::ModeInverse, 32'h8000_0000, 0, 0, 32'h8000_0000, 0, 0);
        add_word(sol2_pkg::ModeInverse, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 0, 0);
        // tiny determinant: saturation both ways
        add_word(sol2_pkg::ModeInverse, 1, 0, 0, 1, 0, 0);
        add_word(sol2_pkg::ModeInverse, 1, 0, 0, 32'hFFFF_FFFF, 0, 0);
        add_word(sol2_pkg::ModeSolve, 1, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        add_word(sol2_pkg::ModeSolve, 32'hFFFF_FFFF, 0, 0, 1, 32'h7FFF_FFFF, 32'h8000_0000);
        // exactly -2^31 quotient (no clip) and truncation toward zero
        add_word(sol2_pkg::ModeSolve, 32'h1_0000, 0, 0, 32'h1_0000, 32'h8000_0000,
                 32'h7FFF_FFFF);
        add_word(sol2_pkg::ModeSolve, 32'h3_0000, 0, 0, 32'h3_0000, 32'hFFFF_FFFF, 32'h1);
        add_word(sol2_pkg::ModeInverse, 32'h3_0000, 32'h1_0000, 32'h2_0000, 32'hFFFF_0000,
                 0, 0);
        add_word(sol2_pkg::ModeSolve, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        for (k = 0; k < NumRandom; k++) begin
            a = rand_entry();
            b = rand_entry();
            c = rand_entry();
            d = rand_entry();
            // force some singular cases: proportional rows
            if ($urandom_range(0, 15) == 0) begin
                c = a;
                d = b;
            end
            add_word(1'($urandom_range(0, 1)), a, b, c, d, rand_entry(), rand_entry());
        end
        stim_done = 1'b1;
    end

    // driver: bursts with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            i_data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else if (!(i_valid && o_stall)) begin
            if (i_valid) begin
                expected_results.push_back(solve_2x2(i_data));
                if (i_data.mode == sol2_pkg::ModeInverse)
                    n_inv++;
            end
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                i_valid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                i_data <= pending_words.pop_front();
                i_valid <= 1'b1;
                if (burst_left > 0) begin
                    burst_left <= burst_left - 1;
                end else begin
                    burst_left <= $urandom_range(0, 40);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // stall pattern: long free stretches, then bursts of random stalling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_phase <= 0;
        end else begin
            stall_phase <= (stall_phase + 1) % 300;
            if (stall_phase < 100)
                i_stall <= 1'b0;
            else if (stall_phase < 200)
                i_stall <= ($urandom_range(0, 3) == 0);
            else
                i_stall <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        sol2_pkg::t_out_word want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("unexpected result word %h", o_data);
                n_errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_data.res0 !== want.res0)
                    report_mismatch("res0", 64'(o_data.res0), 64'(want.res0));
                if (o_data.res1 !== want.res1)
                    report_mismatch("res1", 64'(o_data.res1), 64'(want.res1));
                if (o_data.res2 !== want.res2)
                    report_mismatch("res2", 64'(o_data.res2), 64'(want.res2));
                if (o_data.res3 !== want.res3)
                    report_mismatch("res3", 64'(o_data.res3), 64'(want.res3));
                if (o_data.det_value !== want.det_value)
                    report_mismatch("det_value", o_data.det_value, want.det_value);
                if (o_data.singular !== want.singular)
                    report_mismatch("singular", 64'(o_data.singular), 64'(want.singular));
                if (o_data.saturated !== want.saturated)
                    report_mismatch("saturated", 64'(o_data.saturated), 64'(want.saturated));
                n_singular += want.singular;
                n_clipped += want.saturated;
            end
            n_checked++;
        end
    end

    // watchdog: cycles with no accepted word on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("timeout: no progress with %0d results outstanding",
                     expected_results.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done);
        while (pending_words.size() > 0 || i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (PipeDepth + 10) @(posedge i_clk);
        $display("checked %0d words (%0d inverse, %0d solve)", n_checked, n_inv,
                 n_checked - n_inv);
        $display("singular matrices %0d, clipped quotients in %0d words", n_singular,
                 n_clipped);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/sol2_pkg.sv
hw/rtl/sol2_front.sv
hw/rtl/sol2_prep.sv
hw/rtl/sol2_div_step.sv
hw/rtl/solve_or_invert_2x2_top.sv
tb/sv/tb_solve_or_invert_2x2_top.sv
